[rtl/lif_pkg.sv]
`default_nettype none

package lif_pkg;

	// neuron store
	localparam int NEURON_COUNT = 1024;
	localparam int IDX_W        = 10;
	localparam int ADDR_W       = $clog2(NEURON_COUNT);

	// data widths
	localparam int V_W    = 32;
	localparam int STEP_W = 32;
	localparam int LEAK_W = 16;
	localparam int CFG_W  = 32;
	localparam int Q_FRAC = 16;
	localparam int Q_W    = Q_FRAC + 1;

	// fixed point one and half lsb for rounding
	localparam logic [Q_W-1:0] Q_ONE  = Q_W'(1 << Q_FRAC);
	localparam int             Q_HALF = 1 << (Q_FRAC - 1);

	// shared multiplier operand widths
	localparam int MA_W = V_W + 1;
	localparam int MB_W = Q_W + 1;
	localparam int MP_W = MA_W + MB_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK_RATE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACC,
		OP_SQR,
		OP_VMUL,
		OP_CMUL
	} dp_op_t;

	typedef struct packed {
		logic   clear;
		logic   capture;
		logic   load;
		dp_op_t op;
		logic   commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic exp_zero;
		logic exp_lsb;
		logic spike;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/lif_neuron_event_update.sv]
`default_nettype none
// one item is in work at a time: after the input transfer the block loads the elapsed
// steps, runs the decay power loop, scales voltage and current, then sums and commits
// the shared 33x18 multiplier runs the square-and-multiply loop lsb first, a set exponent
// bit taking a multiply before its square; a spiking commit waits while out_stall holds a result
// reset: after arst_n releases, a clearing sweep zeroes every entry of the voltage and step
// stores with in_stall high; configuration writes are taken during the sweep

module lif_neuron_event_update import lif_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [IDX_W-1:0]      neuron_index,
	input  wire logic [STEP_W-1:0]     now_step,
	input  wire logic signed [V_W-1:0] input_current,
	// spike channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [IDX_W-1:0]           spike_index,
	output logic signed [V_W-1:0]      fired_voltage,
	output logic signed [V_W-1:0]      prior_voltage
);

	// configuration registers
	logic [LEAK_W-1:0]     leak_rate_q;
	logic signed [V_W-1:0] fire_threshold_q;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     idx_ok;

	// config writes land directly, no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_rate_q      <= LEAK_W'(13107);
			fire_threshold_q <= V_W'(65536);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LEAK_RATE:      leak_rate_q      <= cfg_data[LEAK_W-1:0];
				REG_FIRE_THRESHOLD: fire_threshold_q <= cfg_data[V_W-1:0];
				default:            leak_rate_q      <= leak_rate_q;
			endcase
		end
	end

	// an index past the store is taken by the transfer and dropped
	assign idx_ok = ({1'b0, neuron_index} < (IDX_W + 1)'(NEURON_COUNT));

	// sequencer: clear sweep, capture, load, power loop, scale, commit
	lif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.idx_ok   (idx_ok),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// stores, shared multiplier, saturation and the spike output register
	lif_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.neuron_index   (neuron_index),
		.now_step       (now_step),
		.input_current  (input_current),
		.leak_rate      (leak_rate_q),
		.fire_threshold (fire_threshold_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.spike_index    (spike_index),
		.fired_voltage  (fired_voltage),
		.prior_voltage  (prior_voltage)
	);

endmodule

`default_nettype wire

[rtl/lif_dp.sv]
`default_nettype none

module lif_dp import lif_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dp_cmd_t                  cmd,
	output dp_stat_t                      stat,
	input  wire logic [IDX_W-1:0]         neuron_index,
	input  wire logic [STEP_W-1:0]        now_step,
	input  wire logic signed [V_W-1:0]    input_current,
	input  wire logic [LEAK_W-1:0]        leak_rate,
	input  wire logic signed [V_W-1:0]    fire_threshold,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [IDX_W-1:0]              spike_index,
	output logic signed [V_W-1:0]         fired_voltage,
	output logic signed [V_W-1:0]         prior_voltage
);

	localparam logic signed [MP_W-1:0] RND = MP_W'(Q_HALF);

	logic [V_W-1:0]    volt_mem [NEURON_COUNT];
	logic [STEP_W-1:0] step_mem [NEURON_COUNT];

	logic [IDX_W-1:0]      idx_q;
	logic [STEP_W-1:0]     now_q;
	logic signed [V_W-1:0] cur_q;
	logic signed [V_W-1:0] v_rd_q;
	logic [STEP_W-1:0]     s_rd_q;
	logic [STEP_W-1:0]     exp_q;
	logic [Q_W-1:0]        base_q;
	logic [Q_W-1:0]        acc_q;
	logic signed [V_W-1:0] leak_v_q;
	logic signed [V_W-1:0] scaled_q;
	logic [ADDR_W-1:0]     clr_q;
	logic                  out_valid_q;
	logic [IDX_W-1:0]      spike_idx_q;
	logic signed [V_W-1:0] fired_q;
	logic signed [V_W-1:0] prior_q;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] mul_p;
	logic signed [MP_W-1:0] mul_r;
	logic signed [V_W:0]    v_sum;
	logic signed [V_W-1:0]  v_sat;
	logic                   spike;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_wa;
	logic [V_W-1:0]         volt_wd;
	logic [STEP_W-1:0]      step_wd;

	// shared multiplier, rounded half up
	always_comb begin
		case (cmd.op)
			OP_ACC: begin
				mul_a = {{(MA_W-Q_W){1'b0}}, acc_q};
				mul_b = {1'b0, base_q};
			end
			OP_SQR: begin
				mul_a = {{(MA_W-Q_W){1'b0}}, base_q};
				mul_b = {1'b0, base_q};
			end
			OP_VMUL: begin
				mul_a = {v_rd_q[V_W-1], v_rd_q};
				mul_b = {1'b0, acc_q};
			end
			OP_CMUL: begin
				mul_a = {cur_q[V_W-1], cur_q};
				mul_b = {{(MB_W-LEAK_W){1'b0}}, leak_rate};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign mul_r = (mul_p + RND) >>> Q_FRAC;

	// leak plus input, saturated
	assign v_sum = {leak_v_q[V_W-1], leak_v_q} + {scaled_q[V_W-1], scaled_q};

	always_comb begin
		if (v_sum[V_W] != v_sum[V_W-1]) begin
			v_sat = v_sum[V_W] ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}};
		end else begin
			v_sat = v_sum[V_W-1:0];
		end
	end

	assign spike = (v_sat >= fire_threshold);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= neuron_index;
			now_q <= now_step;
			cur_q <= input_current;
		end
		if (cmd.load) begin
			exp_q  <= now_q - s_rd_q;
			base_q <= Q_ONE - {1'b0, leak_rate};
			acc_q  <= Q_ONE;
		end
		case (cmd.op)
			OP_ACC: begin
				acc_q    <= mul_r[Q_W-1:0];
				exp_q[0] <= 1'b0;
			end
			OP_SQR: begin
				base_q <= mul_r[Q_W-1:0];
				exp_q  <= exp_q >> 1;
			end
			OP_VMUL: begin
				leak_v_q <= mul_r[V_W-1:0];
			end
			OP_CMUL: begin
				scaled_q <= mul_r[V_W-1:0];
			end
			default: begin
			end
		endcase
		if (cmd.commit && spike) begin
			spike_idx_q <= idx_q;
			fired_q     <= v_sat;
			prior_q     <= v_rd_q;
		end
	end

	// neuron store, one write port shared by the clearing sweep
	assign mem_we  = cmd.clear || cmd.commit;
	assign mem_wa  = cmd.clear ? clr_q : idx_q[ADDR_W-1:0];
	assign volt_wd = (cmd.clear || spike) ? '0 : v_sat;
	assign step_wd = cmd.clear ? '0 : now_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			volt_mem[mem_wa] <= volt_wd;
			step_mem[mem_wa] <= step_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			v_rd_q <= volt_mem[neuron_index[ADDR_W-1:0]];
			s_rd_q <= step_mem[neuron_index[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.commit && spike) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.clr_last = (clr_q == ADDR_W'(NEURON_COUNT - 1));
	assign stat.exp_zero = (exp_q == '0);
	assign stat.exp_lsb  = exp_q[0];
	assign stat.spike    = spike;
	assign stat.out_busy = out_valid_q && out_stall;

	assign out_valid     = out_valid_q;
	assign spike_index   = spike_idx_q;
	assign fired_voltage = fired_q;
	assign prior_voltage = prior_q;

endmodule

`default_nettype wire

[rtl/lif_ctrl.sv]
`default_nettype none

module lif_ctrl import lif_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     idx_ok,
	input  wire dp_stat_t stat,
	output logic          in_stall,
	output dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_POW,
		ST_VMUL,
		ST_CMUL,
		ST_SUM
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd    = '0;
		cmd.op = OP_NONE;
		case (state_q)
			ST_CLEAR: cmd.clear   = 1'b1;
			ST_IDLE:  cmd.capture = in_valid && idx_ok;
			ST_LOAD:  cmd.load    = 1'b1;
			ST_POW: begin
				if (stat.exp_zero) begin
					cmd.op = OP_NONE;
				end else if (stat.exp_lsb) begin
					cmd.op = OP_ACC;
				end else begin
					cmd.op = OP_SQR;
				end
			end
			ST_VMUL:  cmd.op     = OP_VMUL;
			ST_CMUL:  cmd.op     = OP_CMUL;
			ST_SUM:   cmd.commit = !(stat.spike && stat.out_busy);
			default:  cmd.op     = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && idx_ok) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_POW;
				ST_POW: begin
					if (stat.exp_zero) begin
						state_q <= ST_VMUL;
					end
				end
				ST_VMUL: state_q <= ST_CMUL;
				ST_CMUL: state_q <= ST_SUM;
				ST_SUM: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_capture_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && idx_ok) |=> (state_q == ST_LOAD))
		else $error("accepted item did not start a load");

	a_pow_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POW && !stat.exp_zero) |=> (state_q == ST_POW))
		else $error("decay power left before exponent was consumed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && stat.spike && stat.out_busy))
		else $error("spike committed over a waiting result");

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && !stat.clr_last) |=> (state_q == ST_CLEAR))
		else $error("clearing sweep ended early");

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import lif_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	// pad past the longest spike latency before touching registers
	localparam int DRAIN_CYCLES    = 80;
	localparam int RAND_PHASES     = 5;
	localparam int ITEMS_PER_PHASE = 100;
	localparam longint V_MAX       = 64'sd2147483647;
	localparam longint V_MIN       = -64'sd2147483648;

	// directed row is either an update transfer or a register write
	typedef enum logic {ROW_XFER, ROW_WRITE} row_kind_t;
	// where the expected spike of a row comes from
	typedef enum logic [1:0] {SPK_PREDICT, SPK_NONE, SPK_TYPED} spike_src_t;

	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic signed [V_W-1:0] fired;
		logic signed [V_W-1:0] prior;
	} spike_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] sel;
		logic [CFG_W-1:0]     value;
		logic [IDX_W-1:0]     idx;
		logic [STEP_W-1:0]    now;
		logic [V_W-1:0]       cur;
		spike_src_t           src;
		spike_t               typed;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [IDX_W-1:0]      neuron_index;
	logic [STEP_W-1:0]     now_step;
	logic signed [V_W-1:0] input_current;
	logic                  out_valid;
	logic                  out_stall;
	logic [IDX_W-1:0]      spike_index;
	logic signed [V_W-1:0] fired_voltage;
	logic signed [V_W-1:0] prior_voltage;

	lif_neuron_event_update dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.neuron_index  (neuron_index),
		.now_step      (now_step),
		.input_current (input_current),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.spike_index   (spike_index),
		.fired_voltage (fired_voltage),
		.prior_voltage (prior_voltage)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// shadow of the neuron stores and registers, zero after the reset sweep
	logic signed [V_W-1:0] volt_mem [NEURON_COUNT];
	logic [STEP_W-1:0]     step_mem [NEURON_COUNT];
	logic [LEAK_W-1:0]     leak_q = 16'd13107;
	logic signed [V_W-1:0] thr_q  = 32'sd65536;

	// spikes owed by the block, oldest first
	spike_t    spikes_due [$];
	stim_row_t stim_rows [$];

	int  errors      = 0;
	int  items_sent  = 0;
	int  spikes_seen = 0;
	int  writes_done = 0;
	int  cycle_count = 0;
	int  stall_left  = 0;
	bit  send_calm   = 1'b0;
	bit  recv_calm   = 1'b0;
	logic [STEP_W-1:0] clock_step = '0;

	initial begin
		for (int i = 0; i < NEURON_COUNT; i++) begin
			volt_mem[i] = '0;
			step_mem[i] = '0;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// (1 - leak)^elapsed by square-and-multiply, lsb first, all 32 bits
	function automatic logic [Q_W-1:0] decay_factor(input logic [STEP_W-1:0] elapsed);
		longint unsigned base;
		longint unsigned acc;
		int b;
		base = 64'(Q_ONE - {1'b0, leak_q});
		acc  = 64'(Q_ONE);
		for (b = 0; b < STEP_W; b++) begin
			if (elapsed[b])
				acc = (acc * base + 64'(Q_HALF)) >> Q_FRAC;
			base = (base * base + 64'(Q_HALF)) >> Q_FRAC;
		end
		return acc[Q_W-1:0];
	endfunction

	// floor((p + half) / 2^16), halves go up
	function automatic longint round_q16(input longint p);
		return (p + longint'(Q_HALF)) >>> Q_FRAC;
	endfunction

	// leak and integrate one neuron, update the shadow stores, report a spike
	function automatic bit integrate_neuron(input logic [IDX_W-1:0] idx,
		input logic [STEP_W-1:0] now, input logic signed [V_W-1:0] cur,
		output spike_t spk);
		longint v_old;
		longint v_sum;
		logic [STEP_W-1:0] elapsed;
		v_old   = longint'(volt_mem[idx]);
		elapsed = now - step_mem[idx];
		v_sum   = round_q16(v_old * longint'(decay_factor(elapsed)))
			+ round_q16(longint'(cur) * longint'(leak_q));
		if (v_sum > V_MAX)
			v_sum = V_MAX;
		if (v_sum < V_MIN)
			v_sum = V_MIN;
		step_mem[idx] = now;
		spk.idx   = idx;
		spk.fired = v_sum[V_W-1:0];
		spk.prior = volt_mem[idx];
		if (v_sum >= longint'(thr_q)) begin
			volt_mem[idx] = '0;
			return 1'b1;
		end
		volt_mem[idx] = v_sum[V_W-1:0];
		return 1'b0;
	endfunction

	function automatic void add_xfer(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] now,
		input logic [V_W-1:0] cur, input spike_src_t src, input spike_t typed = '0);
		stim_row_t r;
		r.kind  = ROW_XFER;
		r.sel   = REG_LEAK_RATE;
		r.value = '0;
		r.idx   = idx;
		r.now   = now;
		r.cur   = cur;
		r.src   = src;
		r.typed = typed;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] sel,
		input logic [CFG_W-1:0] value);
		stim_row_t r;
		r.kind  = ROW_WRITE;
		r.sel   = sel;
		r.value = value;
		r.idx   = '0;
		r.now   = '0;
		r.cur   = '0;
		r.src   = SPK_NONE;
		r.typed = '0;
		stim_rows.push_back(r);
	endfunction

	// one input transfer; the shadow model steps when the block takes it
	task automatic accept_item(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] now,
		input logic [V_W-1:0] cur, input spike_src_t src, input spike_t typed);
		spike_t predicted;
		bit fires;
		int gap;
		in_valid      <= 1'b1;
		neuron_index  <= idx;
		now_step      <= now;
		input_current <= cur;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		fires = integrate_neuron(idx, now, cur, predicted);
		items_sent++;
		if (src == SPK_TYPED)
			spikes_due.push_back(typed);
		else if (src == SPK_PREDICT && fires)
			spikes_due.push_back(predicted);
		// back-to-back unless a gap is drawn
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// registers only change once the block has gone quiet
	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] value);
		in_valid <= 1'b0;
		while (spikes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (sel == REG_LEAK_RATE)
			leak_q = value[LEAK_W-1:0];
		else
			thr_q = value;
		writes_done++;
	endtask

	// random update: a small pool of neurons so voltages build up, steps mostly
	// creeping forward with the odd jump or wrap
	task automatic send_random();
		logic [IDX_W-1:0] idx;
		logic [V_W-1:0]   cur;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			idx = IDX_W'($urandom_range(0, 7));
		else if (roll < 95)
			idx = IDX_W'($urandom_range(0, NEURON_COUNT - 1));
		else
			idx = roll[0] ? IDX_W'(NEURON_COUNT - 1) : '0;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			clock_step += $urandom_range(0, 3);
		else if (roll < 90)
			clock_step += $urandom_range(4, 40);
		else if (roll < 95)
			clock_step += $urandom;
		else
			clock_step = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			cur = $urandom_range(0, 32'h60000) - 32'h10000;
		else if (roll < 90)
			cur = $urandom;
		else if (roll < 94)
			cur = 32'h7fff_ffff;
		else if (roll < 98)
			cur = 32'h8000_0000;
		else
			cur = '0;
		accept_item(idx, clock_step, cur, SPK_PREDICT, '0);
	endtask

	// stimulus
	initial begin
		logic [CFG_W-1:0] leak;
		logic [CFG_W-1:0] thr;
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= REG_LEAK_RATE;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		neuron_index  <= '0;
		now_step      <= '0;
		input_current <= '0;

		// reset register values: leak 0.2, threshold 1.0
		add_xfer(10'd0, 32'd0, 32'h0000_0000, SPK_NONE);
		// full positive current on a fresh neuron
		add_xfer(10'd1023, 32'd0, 32'h7fff_ffff, SPK_TYPED,
			spike_t'{10'd1023, 32'sd429490176, 32'sd0});
		add_xfer(10'd5, 32'd0, 32'h8000_0000, SPK_NONE);
		add_xfer(10'd5, 32'd1, 32'h0000_0000, SPK_PREDICT);
		// elapsed with every high bit set
		add_xfer(10'd5, 32'hffff_ffff, 32'h7fff_ffff, SPK_PREDICT);
		// step counter wrapped since last update
		add_xfer(10'd5, 32'd3, 32'h0001_0000, SPK_PREDICT);
		add_xfer(10'h2aa, 32'h5555_5555, 32'h0004_0000, SPK_PREDICT);
		// one lsb under threshold, then landing exactly on it
		add_xfer(10'h155, 32'haaaa_aaaa, 32'h0005_0000, SPK_NONE);
		add_xfer(10'h155, 32'haaaa_aaaa, 32'h0000_0006, SPK_TYPED,
			spike_t'{10'h155, 32'sd65536, 32'sd65535});
		// zero leak: no decay and no current
		add_write(REG_LEAK_RATE, 32'd0);
		add_xfer(10'd7, 32'd100, 32'h7fff_ffff, SPK_NONE);
		add_xfer(10'd5, 32'd200, 32'h7fff_ffff, SPK_PREDICT);
		// lowest threshold: everything fires
		add_write(REG_FIRE_THRESHOLD, 32'h8000_0000);
		add_xfer(10'd7, 32'd101, 32'h1234_5678, SPK_TYPED, spike_t'{10'd7, 32'sd0, 32'sd0});
		add_xfer(10'd5, 32'd300, 32'hffff_ffff, SPK_PREDICT);
		// fastest leak, top threshold: saturation both ways
		add_write(REG_LEAK_RATE, 32'hffff_ffff);
		add_write(REG_FIRE_THRESHOLD, 32'h7fff_ffff);
		add_xfer(10'd9, 32'd0, 32'h7fff_ffff, SPK_PREDICT);
		add_xfer(10'd9, 32'd0, 32'h7fff_ffff, SPK_PREDICT);
		add_xfer(10'd11, 32'd0, 32'h8000_0000, SPK_PREDICT);
		add_xfer(10'd11, 32'd0, 32'h8000_0000, SPK_PREDICT);
		add_xfer(10'd11, 32'd1, 32'h0000_0000, SPK_PREDICT);
		add_write(REG_LEAK_RATE, 32'd13107);
		add_write(REG_FIRE_THRESHOLD, 32'd65536);
		add_xfer(10'd1023, 32'hffff_ffff, 32'hffff_0000, SPK_PREDICT);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// the block holds in_stall through its clearing sweep

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_WRITE)
				write_reg(stim_rows[i].sel, stim_rows[i].value);
			else
				accept_item(stim_rows[i].idx, stim_rows[i].now, stim_rows[i].cur,
					stim_rows[i].src, stim_rows[i].typed);
		end

		// random phases, each under its own leak and threshold
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			send_calm = (phase == 2);
			recv_calm = (phase == 3);
			case (phase)
				0: begin
					leak = 32'd13107;
					thr  = 32'd65536;
				end
				1: begin
					leak = $urandom;
					thr  = $urandom_range(32'h8000, 32'h40000);
				end
				2: begin
					leak = $urandom_range(60000, 65535);
					thr  = $urandom_range(0, 32'h20000);
				end
				3: begin
					leak = $urandom_range(1, 2000);
					thr  = $urandom;
				end
				default: begin
					leak = $urandom_range(0, 65535);
					thr  = -$urandom_range(0, 32'h10000);
				end
			endcase
			write_reg(REG_LEAK_RATE, leak);
			write_reg(REG_FIRE_THRESHOLD, thr);
			clock_step = $urandom;
			repeat (ITEMS_PER_PHASE) send_random();
		end

		// let the last spikes and any silent update finish
		in_valid <= 1'b0;
		while (spikes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d neuron updates, %0d spikes, %0d register writes in %0d cycles",
			items_sent, spikes_seen, writes_done, cycle_count);
		$display("leak from zero to full, thresholds at both ends, step wrap and saturation");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// spike sink: check each transfer against the oldest owed spike
	initial begin : spike_sink
		spike_t want;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (spikes_due.size() == 0) begin
					$error("spike transfer with none due, spike_index %0d", spike_index);
					errors++;
				end else begin
					want = spikes_due.pop_front();
					spikes_seen++;
					if (spike_index !== want.idx) begin
						$error("spike_index: expected %0d, got %0d", want.idx, spike_index);
						errors++;
					end
					if (fired_voltage !== want.fired) begin
						$error("fired_voltage: expected %0d, got %0d", want.fired,
							fired_voltage);
						errors++;
					end
					if (prior_voltage !== want.prior) begin
						$error("prior_voltage: expected %0d, got %0d", want.prior,
							prior_voltage);
						errors++;
					end
				end
			end
			// random back-pressure, held for a drawn number of cycles
			if (stall_left == 0)
				stall_left = pick_gap(recv_calm);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else
				out_stall <= 1'b0;
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("no finish after %0d cycles", cycle_count);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
